@@ rtl/kda_pkg.sv @@
// Package for the key debouncer with auto-repeat.
// Holds widths, key and register codes, reset values and the config, state and event types.
// No dependencies; imported by kda_step, key_debounce_autorepeat and its testbench.
package kda_pkg;

  localparam int COUNT_BITS = 8;
  localparam int REG_W      = 8;
  localparam int CFG_IDX_W  = 4;

  // key status codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_UP   = 2'd1;
  localparam logic [1:0] KEY_DN   = 2'd2;
  localparam logic [1:0] KEY_BOTH = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT_DELAY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_REPEAT_PERIOD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_REPEAT_PERIOD = CFG_IDX_W'(3);

  // register reset values
  localparam logic [REG_W-1:0] SCAN_INTERVAL_RST = REG_W'(10);
  localparam logic [REG_W-1:0] FIRST_DELAY_RST   = REG_W'(50);
  localparam logic [REG_W-1:0] SLOW_PERIOD_RST   = REG_W'(10);
  localparam logic [REG_W-1:0] FAST_PERIOD_RST   = REG_W'(3);

  typedef struct packed {
    logic [REG_W-1:0] scan_interval;
    logic [REG_W-1:0] first_repeat_delay;
    logic [REG_W-1:0] slow_repeat_period;
    logic [REG_W-1:0] fast_repeat_period;
  } kda_cfg_t;

  typedef struct packed {
    logic [REG_W-1:0]      prescale_count;
    logic [1:0]            last_status;
    logic [1:0]            accepted_code;
    logic                  repeat_flag;
    logic                  first_phase;
    logic                  repeat_armed;
    logic [COUNT_BITS-1:0] repeat_count;
    logic                  fast_mode;
  } kda_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] key_code;
    logic       is_repeat;
  } kda_event_t;

endpackage

@@ rtl/kda_step.sv @@
// One tick of the debouncer: prescaler, sampling and the repeat logic.
// Purely combinational next state and event; depends on kda_pkg.
module kda_step
  import kda_pkg::*;
(
  input  kda_cfg_t   cfg,
  input  kda_state_t state,
  input  logic       up_pin,
  input  logic       down_pin,
  input  logic       fast_set,
  output kda_state_t state_nxt,
  output kda_event_t evt
);

  always_comb begin
    kda_state_t            s;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] period;
    logic [COUNT_BITS-1:0] delay;
    logic                  hit;

    s      = state;
    hit    = 1'b0;
    status = {~down_pin, ~up_pin};
    delay  = COUNT_BITS'(cfg.first_repeat_delay);
    period = state.fast_mode ? COUNT_BITS'(cfg.fast_repeat_period)
                             : COUNT_BITS'(cfg.slow_repeat_period);

    if (s.prescale_count != '0) begin
      s.prescale_count = s.prescale_count - REG_W'(1);
    end

    if (s.prescale_count == '0) begin
      if (status == s.last_status) begin
        if (s.last_status != KEY_NONE) begin
          if (s.accepted_code == s.last_status) begin
            if (s.repeat_armed) begin
              s.repeat_count = s.repeat_count + COUNT_BITS'(1);
              if (s.first_phase) begin
                if (s.repeat_count == delay) begin
                  s.repeat_count = '0;
                  s.first_phase  = 1'b0;
                  hit            = 1'b1;
                end
              end else begin
                s.repeat_flag = 1'b1;
                if (s.repeat_count == period) begin
                  s.repeat_count = '0;
                  hit            = 1'b1;
                end
              end
            end
          end else begin
            // newly stable key: one event, then arm the repeat
            s.accepted_code = s.last_status;
            hit             = 1'b1;
            s.repeat_flag   = 1'b0;
            s.first_phase   = 1'b1;
            s.repeat_armed  = 1'b1;
            s.repeat_count  = '0;
            s.fast_mode     = 1'b0;
          end
        end else begin
          s.accepted_code = KEY_NONE;
        end
      end else begin
        s.last_status  = status;
        s.repeat_flag  = 1'b0;
        s.first_phase  = 1'b1;
        s.repeat_armed = 1'b0;
        s.repeat_count = '0;
        s.fast_mode    = 1'b0;
      end
      s.prescale_count = cfg.scan_interval;
    end

    // fast request lands after the key logic of this tick
    if (fast_set) begin
      s.fast_mode = 1'b1;
    end

    state_nxt     = s;
    evt.valid     = hit;
    evt.key_code  = s.accepted_code;
    evt.is_repeat = s.repeat_flag;
  end

endmodule

@@ rtl/key_debounce_autorepeat.sv @@
// Top level of the two-key debouncer with auto-repeat.
// Holds the configuration, state and result registers; depends on kda_pkg, kda_step.
//
// Usage:
//   Each input beat (in_up_pin, in_down_pin, in_fast_set) is one timer tick.
//   The pins are active low. Every scan_interval ticks the keys are sampled;
//   a status seen on two successive samples is stable. A newly stable pressed
//   key gives one result beat (out_key_code, out_is_repeat = 0), and while it
//   is held repeats follow after first_repeat_delay samples and then every
//   slow or fast period. Most ticks give no result beat.
//   Throughput: one tick per cycle while in_ready is high. The whole tick update
//   runs through one level of logic from the input beat into the state and result
//   registers, so a result shows in the cycle after the tick that made it.
//   Stall: the result register holds a beat until out_ready takes it; while
//   it is full and out_ready is low, in_ready drops and ticks wait. A tick
//   is still taken in the cycle the waiting beat leaves.
//   Reset (rst_n low, synchronous): registers return to 10/50/10/3, the
//   prescaler to 10, all key and repeat state to idle, no result pending.
//   Configuration: cfg_we writes register cfg_index from cfg_wdata; indexes
//   beyond the four registers are dropped. Write only while idle.
module key_debounce_autorepeat
  import kda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_up_pin,
  input  logic                 in_down_pin,
  input  logic                 in_fast_set,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_key_code,
  output logic                 out_is_repeat
);

  kda_cfg_t   cfg_r;
  kda_state_t state_r;
  kda_state_t state_nxt;
  kda_event_t evt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] out_key_code_r;
  logic       out_is_repeat_r;
  logic       in_accept;

  kda_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .up_pin    (in_up_pin),
    .down_pin  (in_down_pin),
    .fast_set  (in_fast_set),
    .state_nxt (state_nxt),
    .evt       (evt)
  );

  // take a tick whenever the result register is empty or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = evt.valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_interval      <= SCAN_INTERVAL_RST;
      cfg_r.first_repeat_delay <= FIRST_DELAY_RST;
      cfg_r.slow_repeat_period <= SLOW_PERIOD_RST;
      cfg_r.fast_repeat_period <= FAST_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_INTERVAL:      cfg_r.scan_interval      <= cfg_wdata;
        CFG_FIRST_REPEAT_DELAY: cfg_r.first_repeat_delay <= cfg_wdata;
        CFG_SLOW_REPEAT_PERIOD: cfg_r.slow_repeat_period <= cfg_wdata;
        CFG_FAST_REPEAT_PERIOD: cfg_r.fast_repeat_period <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // key and repeat state; advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prescale_count <= SCAN_INTERVAL_RST;
      state_r.last_status    <= KEY_NONE;
      state_r.accepted_code  <= KEY_NONE;
      state_r.repeat_flag    <= 1'b0;
      state_r.first_phase    <= 1'b1;
      state_r.repeat_armed   <= 1'b0;
      state_r.repeat_count   <= '0;
      state_r.fast_mode      <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // result register: valid under reset, payload loads with each event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && evt.valid) begin
      out_key_code_r  <= evt.key_code;
      out_is_repeat_r <= evt.is_repeat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_key_code_r;
  assign out_is_repeat = out_is_repeat_r;

endmodule

@@ verif/key_debounce_autorepeat_tb.sv @@
// Self-checking testbench for key_debounce_autorepeat: ticks, predictor and scoreboard.
// A queue-fed driver and a clocked monitor check every result beat against a local model.
// Depends on kda_pkg and the key_debounce_autorepeat RTL.
module key_debounce_autorepeat_tb
  import kda_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One timer tick as offered on the input channel.
  typedef struct packed {
    logic up_pin;
    logic down_pin;
    logic fast_set;
  } tick_t;

  // One key event as it should leave the result channel.
  typedef struct packed {
    logic [1:0] key_code;
    logic       is_repeat;
  } key_event_t;

  localparam int TICK_BUDGET = 240;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [REG_W-1:0]     cfg_wdata     = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_up_pin     = 1'b1;
  logic                 in_down_pin   = 1'b1;
  logic                 in_fast_set   = 1'b0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [1:0]           out_key_code;
  logic                 out_is_repeat;

  key_debounce_autorepeat u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_up_pin    (in_up_pin),
    .in_down_pin  (in_down_pin),
    .in_fast_set  (in_fast_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code),
    .out_is_repeat(out_is_repeat)
  );

  // 2 ns clock: low first, so the first rising edge lands at 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tick_t      tick_backlog[$];     // ticks waiting for the driver
  key_event_t expected_events[$];  // predicted events not yet seen on out_*
  int         mismatches = 0;
  logic       in_taken   = 1'b0;   // input beat accepted at the last rising edge
  logic       no_idle    = 1'b0;   // suppress random idling on both sides
  logic       rx_hold    = 1'b0;   // long receiver hold-off, owned by the sequencer
  int         in_gap     = 0;
  int         rx_gap     = 0;
  tick_t      next_tick;

  // ---------------------------------------------------------------------------
  // Debouncer model: register copies and key/repeat state at the block's widths
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0]      reg_scan, reg_delay, reg_slow, reg_fast;
  logic [REG_W-1:0]      prescale;
  logic [1:0]            last_status, accepted_code;
  logic                  repeat_flag, first_phase, repeat_armed, fast_mode;
  logic [COUNT_BITS-1:0] repeat_count;

  task automatic clear_repeat_state();
    repeat_flag  = 1'b0;
    first_phase  = 1'b1;
    repeat_armed = 1'b0;
    repeat_count = '0;
    fast_mode    = 1'b0;
  endtask

  task automatic reset_debouncer_model();
    reg_scan      = SCAN_INTERVAL_RST;
    reg_delay     = FIRST_DELAY_RST;
    reg_slow      = SLOW_PERIOD_RST;
    reg_fast      = FAST_PERIOD_RST;
    prescale      = SCAN_INTERVAL_RST;
    last_status   = KEY_NONE;
    accepted_code = KEY_NONE;
    clear_repeat_state();
  endtask

  // Register writes never touch the running prescaler; unknown indexes drop.
  task automatic write_model_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    case (idx)
      CFG_SCAN_INTERVAL:      reg_scan  = val;
      CFG_FIRST_REPEAT_DELAY: reg_delay = val;
      CFG_SLOW_REPEAT_PERIOD: reg_slow  = val;
      CFG_FAST_REPEAT_PERIOD: reg_fast  = val;
      default: ;
    endcase
  endtask

  // Advance the model by one tick and queue the key event it yields, if any.
  task automatic predict_key_event(input tick_t t);
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] period;
    logic                  fire;
    status = {~t.down_pin, ~t.up_pin};
    fire   = 1'b0;
    // Hold the prescaler at zero once there: a zero reload samples every tick.
    if (prescale != '0) prescale = prescale - REG_W'(1);
    if (prescale == '0) begin
      if (status == last_status) begin
        if (last_status != KEY_NONE) begin
          if (accepted_code == last_status) begin
            if (repeat_armed) begin
              // Wrap the counter; a register masked to zero matches after a full lap.
              repeat_count = repeat_count + COUNT_BITS'(1);
              if (first_phase) begin
                if (repeat_count == COUNT_BITS'(reg_delay)) begin
                  repeat_count = '0;
                  first_phase  = 1'b0;
                  fire         = 1'b1;
                end
              end else begin
                period      = fast_mode ? COUNT_BITS'(reg_fast) : COUNT_BITS'(reg_slow);
                repeat_flag = 1'b1;
                if (repeat_count == period) begin
                  repeat_count = '0;
                  fire         = 1'b1;
                end
              end
            end
          end else begin
            // Newly stable press: one event, then arm the repeat logic.
            accepted_code = last_status;
            fire          = 1'b1;
            clear_repeat_state();
            repeat_armed  = 1'b1;
          end
        end else begin
          accepted_code = KEY_NONE;
        end
      end else begin
        last_status = status;
        clear_repeat_state();
      end
      prescale = reg_scan;
    end
    // Apply the fast request after the key logic, so a change this tick keeps it.
    if (t.fast_set) fast_mode = 1'b1;
    if (fire) expected_events.push_back('{key_code: accepted_code, is_repeat: repeat_flag});
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, track config and ticks, score results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      reset_debouncer_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result beat with nothing expected: key_code=%0d is_repeat=%0b",
                   $time, out_key_code, out_is_repeat);
          mismatches++;
        end else if (out_key_code !== expected_events[0].key_code ||
                     out_is_repeat !== expected_events[0].is_repeat) begin
          $display({"%0t: mismatch: expected key_code=%0d is_repeat=%0b,",
                    " got key_code=%0d is_repeat=%0b"},
                   $time, expected_events[0].key_code, expected_events[0].is_repeat,
                   out_key_code, out_is_repeat);
          mismatches++;
          void'(expected_events.pop_front());
        end else begin
          void'(expected_events.pop_front());
        end
      end
      if (cfg_we) write_model_reg(cfg_index, cfg_wdata);
      if (in_taken) predict_key_event('{up_pin: in_up_pin, down_pin: in_down_pin,
                                        fast_set: in_fast_set});
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next tick at the falling edge once the slot is free
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        // Open an idle burst, this one included; in_gap holds the further idle slots.
        in_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        next_tick = tick_backlog.pop_front();
        in_valid    <= 1'b1;
        in_up_pin   <= next_tick.up_pin;
        in_down_pin <= next_tick.down_pin;
        in_fast_set <= next_tick.fast_set;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when calm.
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      rx_gap = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic up, input logic down, input logic fast);
    tick_backlog.push_back('{up_pin: up, down_pin: down, fast_set: fast});
  endtask

  // Hold one key status for n ticks; fast_pct is the chance of a fast request.
  task automatic push_hold(input logic [1:0] status, input int n, input int fast_pct);
    repeat (n) push_tick(~status[0], ~status[1], $urandom_range(0, 99) < fast_pct);
  endtask

  // Mostly well-formed presses with random length and key, some releases and bounce.
  task automatic push_random(input int n, input int scan);
    int left, len, pick, step;
    logic [1:0] key;
    left = n;
    step = (scan == 0) ? 1 : scan;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        key = 2'($urandom_range(1, 3));
        len = $urandom_range(3, 24) * step;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(60, 300) * step;
      end else if (pick < 85) begin
        key = KEY_NONE;
        len = $urandom_range(1, 6) * step;
      end else begin
        key = 2'bxx;
        len = $urandom_range(1, 8);
      end
      if (len > left) len = left;
      if (key === 2'bxx) begin
        repeat (len) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 7) == 0);
      end else begin
        push_hold(key, len, $urandom_range(0, 1) ? 0 : 4);
      end
      left -= len;
    end
  endtask

  // Mostly small register values, now and then anything the 8 bits allow.
  function automatic logic [REG_W-1:0] pick_reg_value(input int lo, input int hi);
    if ($urandom_range(0, 9) == 0) return REG_W'($urandom_range(0, 255));
    return REG_W'($urandom_range(lo, hi));
  endfunction

  // Wait until every tick is in and every predicted event is out, plus slack.
  task automatic wait_drained();
    while (tick_backlog.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drain, then load all four registers; sometimes poke an unused index too.
  task automatic apply_settings(input logic [REG_W-1:0] scan, input logic [REG_W-1:0] delay,
                                input logic [REG_W-1:0] slow, input logic [REG_W-1:0] fast);
    wait_drained();
    write_reg(CFG_SCAN_INTERVAL, scan);
    write_reg(CFG_FIRST_REPEAT_DELAY, delay);
    write_reg(CFG_SLOW_REPEAT_PERIOD, slow);
    write_reg(CFG_FAST_REPEAT_PERIOD, fast);
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 2**CFG_IDX_W - 1)), REG_W'($urandom_range(0, 255)));
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    int               random_total;
    int               n;
    logic [REG_W-1:0] scan;
    random_total = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Run on the reset values first: sample every 10 ticks, first repeat after 50.
    push_hold(KEY_UP, 40, 0);
    push_hold(KEY_NONE, 10, 0);
    push_hold(KEY_BOTH, 60, 10);

    // Directed: sample every tick, short delay and periods, every key status.
    apply_settings(8'd0, 8'd2, 8'd2, 8'd1);
    push_hold(KEY_UP, 7, 0);       // up held, but no sample falls in these ticks (prescaler still on its old reload)
    push_tick(1'b1, 1'b0, 1'b1);   // change to down with a fast request on the same tick
    push_hold(KEY_DN, 5, 0);
    push_tick(1'b1, 1'b0, 1'b1);   // fast request while held
    push_hold(KEY_DN, 3, 0);
    push_hold(KEY_BOTH, 4, 25);
    push_hold(KEY_NONE, 2, 0);     // release
    push_tick(1'b0, 1'b1, 1'b0);   // bounce between up and none
    push_tick(1'b1, 1'b1, 1'b0);

    // Lowest nonzero settings.
    apply_settings(8'd0, 8'd1, 8'd1, 8'd1);
    push_random(80, 0);

    // Zero delay and periods: the repeat counter must wrap a full lap to match.
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
    push_hold(KEY_DN, 530, 0);

    // Back-pressure: keep a key held and offering ticks while the receiver
    // holds off long enough for the result register to fill and stall input.
    apply_settings(8'd0, 8'd3, 8'd1, 8'd1);
    push_hold(KEY_UP, 150, 0);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;

    // Highest settings: sparse samples, one press event per hold.
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255);
    push_hold(KEY_BOTH, 270, 0);

    // Random phases, each with its own register set.
    while (random_total < TICK_BUDGET) begin
      scan = pick_reg_value(0, 3);
      apply_settings(scan, pick_reg_value(1, 8), pick_reg_value(1, 6), pick_reg_value(1, 6));
      n = $urandom_range(60, 110);
      push_random(n, int'(scan));
      random_total += n;
    end

    // Closing stretch without any idling.
    apply_settings(8'd1, 8'd2, 8'd3, 8'd2);
    no_idle = 1'b1;
    push_random(100, 1);

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("key_debounce_autorepeat_tb OK");
    end else begin
      $display("key_debounce_autorepeat_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("key_debounce_autorepeat_tb NOT OK");
    $finish;
  end

endmodule

@@ key_debounce_autorepeat.f @@
rtl/kda_pkg.sv
rtl/kda_step.sv
rtl/key_debounce_autorepeat.sv
verif/key_debounce_autorepeat_tb.sv
